// File: sv/biq_pkg.sv
// ----------------------------------------------------------------------------
// biq_pkg
// Shared constants and types for the direct form 1 biquad filter.
// ----------------------------------------------------------------------------
package biq_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COEF_WIDTH_DEF   = 18;
  localparam int NUM_COEFS        = 5;
  localparam int CFG_INDEX_W      = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    COEF_B0 = 3'd0,
    COEF_B1 = 3'd1,
    COEF_B2 = 3'd2,
    COEF_A1 = 3'd3,
    COEF_A2 = 3'd4
  } coef_idx_t;

  typedef struct packed {
    logic advance;
    logic clear;
  } hist_ctrl_t;

endpackage

// File: sv/biq_coef_regs.sv
// ----------------------------------------------------------------------------
// biq_coef_regs
// Coefficient register file. Flags a history clear on every write to a
// defined register.
// ----------------------------------------------------------------------------
module biq_coef_regs #(
  parameter int COEF_WIDTH = biq_pkg::COEF_WIDTH_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             cfg_we,
  input  logic [biq_pkg::CFG_INDEX_W-1:0]                  cfg_index,
  input  logic [COEF_WIDTH-1:0]                            cfg_wdata,
  output logic [biq_pkg::NUM_COEFS-1:0][COEF_WIDTH-1:0]    coefs,
  output logic                                             coef_written
);

  localparam logic [COEF_WIDTH-1:0] UNITY = {2'b01, {(COEF_WIDTH-2){1'b0}}};
  localparam logic [biq_pkg::NUM_COEFS-1:0][COEF_WIDTH-1:0] COEF_RESET =
    {{((biq_pkg::NUM_COEFS-1)*COEF_WIDTH){1'b0}}, UNITY};

  logic [biq_pkg::NUM_COEFS-1:0][COEF_WIDTH-1:0] coef_r;
  logic [biq_pkg::NUM_COEFS-1:0][COEF_WIDTH-1:0] coef_nxt;
  logic                                          hit;

  always_comb begin
    coef_nxt = coef_r;
    hit      = 1'b0;
    case (biq_pkg::coef_idx_t'(cfg_index))
      biq_pkg::COEF_B0: begin
        coef_nxt[biq_pkg::COEF_B0] = cfg_wdata;
        hit = 1'b1;
      end
      biq_pkg::COEF_B1: begin
        coef_nxt[biq_pkg::COEF_B1] = cfg_wdata;
        hit = 1'b1;
      end
      biq_pkg::COEF_B2: begin
        coef_nxt[biq_pkg::COEF_B2] = cfg_wdata;
        hit = 1'b1;
      end
      biq_pkg::COEF_A1: begin
        coef_nxt[biq_pkg::COEF_A1] = cfg_wdata;
        hit = 1'b1;
      end
      biq_pkg::COEF_A2: begin
        coef_nxt[biq_pkg::COEF_A2] = cfg_wdata;
        hit = 1'b1;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= COEF_RESET;
    end else if (cfg_we && hit) begin
      coef_r <= coef_nxt;
    end
  end

  assign coefs        = coef_r;
  assign coef_written = cfg_we && hit;

endmodule

// File: sv/biq_datapath.sv
// ----------------------------------------------------------------------------
// biq_datapath
// Delay line and single-pass sum of products with round and saturate.
// ----------------------------------------------------------------------------
module biq_datapath #(
  parameter int SAMPLE_WIDTH = biq_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = biq_pkg::COEF_WIDTH_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  biq_pkg::hist_ctrl_t                           ctrl,
  input  logic [biq_pkg::NUM_COEFS-1:0][COEF_WIDTH-1:0] coefs,
  input  logic [SAMPLE_WIDTH-1:0]                       x,
  output logic [SAMPLE_WIDTH-1:0]                       y,
  output logic                                          clip
);

  localparam int COEF_FRAC = COEF_WIDTH - 2;
  localparam int PROD_W    = COEF_WIDTH + SAMPLE_WIDTH;
  localparam int ACC_W     = PROD_W + 4;

  localparam logic signed [ACC_W-1:0] HALF =
    {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC - 1);
  localparam logic signed [ACC_W-1:0] SMAX =
    {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SMIN =
    {{(ACC_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

  logic [SAMPLE_WIDTH-1:0] xd1_r, xd2_r, yd1_r, yd2_r;

  logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [ACC_W-1:0]  sum;
  logic signed [ACC_W-1:0]  rounded;

  function automatic logic signed [ACC_W-1:0] sext(input logic signed [PROD_W-1:0] p);
    sext = {{(ACC_W-PROD_W){p[PROD_W-1]}}, p};
  endfunction

  always_comb begin
    p_b0 = $signed(coefs[biq_pkg::COEF_B0]) * $signed(x);
    p_b1 = $signed(coefs[biq_pkg::COEF_B1]) * $signed(xd1_r);
    p_b2 = $signed(coefs[biq_pkg::COEF_B2]) * $signed(xd2_r);
    p_a1 = $signed(coefs[biq_pkg::COEF_A1]) * $signed(yd1_r);
    p_a2 = $signed(coefs[biq_pkg::COEF_A2]) * $signed(yd2_r);
    sum  = sext(p_b0) + sext(p_b1) + sext(p_b2) - sext(p_a1) - sext(p_a2);
    rounded = (sum + HALF) >>> COEF_FRAC;
    if (rounded > SMAX) begin
      y    = SMAX[SAMPLE_WIDTH-1:0];
      clip = 1'b1;
    end else if (rounded < SMIN) begin
      y    = SMIN[SAMPLE_WIDTH-1:0];
      clip = 1'b1;
    end else begin
      y    = rounded[SAMPLE_WIDTH-1:0];
      clip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      xd1_r <= '0;
      xd2_r <= '0;
      yd1_r <= '0;
      yd2_r <= '0;
    end else if (ctrl.advance) begin
      xd2_r <= xd1_r;
      xd1_r <= x;
      yd2_r <= yd1_r;
      yd1_r <= y;
    end
  end

endmodule

// File: sv/biquad_df1_filter.sv
// ----------------------------------------------------------------------------
// biquad_df1_filter
// Second-order IIR filter, direct form 1, with signed coefficients of
// COEF_WIDTH-2 fraction bits written through cfg_* (index 0..4: b0, b1, b2,
// a1, a2; b0 resets to 1.0). A write to a defined index clears the filter
// history. Each input word gives one output word y = b0*x + b1*x1 + b2*x2 -
// a1*y1 - a2*y2, rounded half up and saturated, with out_clipped set on
// saturation. One word is accepted per cycle unless out_ready stalls; it moves
// from input register s1 to the result register, setting out_valid. The rate
// is set by the combinational pass through five multipliers, fed back by y.
// ----------------------------------------------------------------------------
module biquad_df1_filter #(
  parameter int SAMPLE_WIDTH = biq_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = biq_pkg::COEF_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [biq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [COEF_WIDTH-1:0]           cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [SAMPLE_WIDTH-1:0]         in_sample_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [SAMPLE_WIDTH-1:0]         out_sample_out,
  output logic                            out_clipped
);

  logic [biq_pkg::NUM_COEFS-1:0][COEF_WIDTH-1:0] coefs;
  logic                                          coef_written;
  biq_pkg::hist_ctrl_t                           ctrl;

  logic                    s1_valid_r;
  logic [SAMPLE_WIDTH-1:0] s1_sample_r;
  logic                    out_valid_r;
  logic [SAMPLE_WIDTH-1:0] out_sample_r;
  logic                    out_clipped_r;
  logic                    s1_advance;
  logic [SAMPLE_WIDTH-1:0] y;
  logic                    clip;

  biq_coef_regs #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_coef_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .coefs        (coefs),
    .coef_written (coef_written)
  );

  assign s1_advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready     = !s1_valid_r || s1_advance;
  assign ctrl.advance = s1_advance;
  assign ctrl.clear   = coef_written;

  biq_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_datapath (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .coefs (coefs),
    .x     (s1_sample_r),
    .y     (y),
    .clip  (clip)
  );

  // hold input word until the result register frees up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample_r <= in_sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_sample_r  <= y;
      out_clipped_r <= clip;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_clipped    = out_clipped_r;

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_advance |=> out_valid_r)
    else $error("result register not loaded after advance");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a blocked result");

  a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_clipped_r) |->
      (out_sample_r == {1'b0, {(SAMPLE_WIDTH-1){1'b1}}} ||
       out_sample_r == {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}))
    else $error("clipped word not at a sample limit");

endmodule
